FILE: sv/cti_pkg.sv
`default_nettype none
package cti_pkg;

  // command codes of a request
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // configuration register map
  localparam int unsigned CFG_AW = 3;
  localparam logic [CFG_AW-1:0] ADDR_POINT_COUNT = 3'd0;
  localparam logic [8:0] POINT_COUNT_RST = 9'd2;

  // fraction one in unsigned q0.16 with one extra bit
  localparam logic [16:0] FRAC_ONE = 17'd65536;

  // width of the horner accumulator
  localparam int unsigned ACC_W = 40;

  localparam logic signed [ACC_W-1:0] SAT_MAX = 40'sd2147483647;
  localparam logic signed [ACC_W-1:0] SAT_MIN = -40'sd2147483648;

endpackage
`default_nettype wire

FILE: sv/cti_if.sv
`default_nettype none
interface cti_in_if;
  logic               valid;
  logic               ready;
  logic               command;
  logic [7:0]         point_index;
  logic signed [31:0] x_value;
  logic signed [31:0] y_value;

  modport source (output valid, command, point_index, x_value, y_value, input ready);
  modport sink   (input valid, command, point_index, x_value, y_value, output ready);
endinterface

interface cti_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] y_result;
  logic [7:0]         segment_found;

  modport source (output valid, y_result, segment_found, input ready);
  modport sink   (input valid, y_result, segment_found, output ready);
endinterface
`default_nettype wire

FILE: sv/cubic_table_interpolator.sv
// channel   dir  payload                                     handshake
// in_ch     in   command, point_index, x_value, y_value      valid/ready
// out_ch    out  y_result, segment_found                     valid/ready
// apb       in   point_count at byte address 0               psel/penable, pready high
//
// a load is written to the table when it is accepted; a query passes through accept and
// end-point reads, binary search steps on the single table read port, the fetch reads,
// the bit-serial restoring divider, the horner multiply-add steps and the output state;
// queries beyond an end finish after the end reads
// reset clears control state and sets point_count to 2; the table is not cleared
// a held result does not block a new request; a query waits at its end until
// the output register is free
`default_nettype none
module cubic_table_interpolator
  import cti_pkg::*;
#(
  parameter int unsigned MAX_POINTS = 256
) (
  input  wire logic               clk,
  input  wire logic               rst,
  cti_in_if.sink                  in_ch,
  cti_out_if.source               out_ch,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [CFG_AW-1:0]  paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  localparam int unsigned AW = $clog2(MAX_POINTS);
  localparam int unsigned NW = ($clog2(MAX_POINTS + 1) > 9) ? $clog2(MAX_POINTS + 1) : 9;

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_FIRST = 12'b000000000010,
    S_LAST  = 12'b000000000100,
    S_SRCH  = 12'b000000001000,
    S_CMP   = 12'b000000010000,
    S_FETCH = 12'b000000100000,
    S_DIVI  = 12'b000001000000,
    S_DIV   = 12'b000010000000,
    S_COEF  = 12'b000100000000,
    S_MUL   = 12'b001000000000,
    S_ADD   = 12'b010000000000,
    S_DONE  = 12'b100000000000
  } state_t;

  state_t state;

  // configuration register
  logic [8:0] point_count;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_POINT_COUNT);
  assign prdata = (paddr == ADDR_POINT_COUNT) ? {23'd0, point_count} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= POINT_COUNT_RST;
    end else if (cfg_wr) begin
      point_count <= pwdata[8:0];
    end
  end

  // effective point count saturated to 2..MAX_POINTS
  logic [NW-1:0] pc_ext, n_sat;
  assign pc_ext = NW'(point_count);
  always_comb begin
    if (pc_ext < NW'(2)) n_sat = NW'(2);
    else if (pc_ext > NW'(MAX_POINTS)) n_sat = NW'(MAX_POINTS);
    else n_sat = pc_ext;
  end

  // table memory, x in the upper half and y in the lower half
  logic [63:0]   mem [MAX_POINTS];
  logic [63:0]   rdata;
  logic [AW-1:0] raddr;
  logic          wen;
  logic [AW-1:0] waddr;

  assign waddr = AW'(in_ch.point_index);
  assign wen   = in_ch.valid && in_ch.ready && (in_ch.command == CMD_LOAD)
                 && (NW'(in_ch.point_index) < NW'(MAX_POINTS));

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= {in_ch.x_value, in_ch.y_value};
    end
    rdata <= mem[raddr];
  end

  logic signed [31:0] rd_x, rd_y;
  assign rd_x = rdata[63:32];
  assign rd_y = rdata[31:0];

  // query working registers
  logic [NW-1:0]      n_q;
  logic signed [31:0] xq, x0, y0e, xi, x1, ym, yi, y1, y2;
  logic               up;
  logic [NW-1:0]      lo1, hi;
  logic [AW-1:0]      mid_q, seg_i;
  logic               cubic;
  logic [2:0]         fc;
  logic [32:0]        ad;
  logic [33:0]        rem;
  logic [16:0]        quo, frac;
  logic [4:0]         dcnt;
  logic signed [ACC_W-1:0] t, c1, c2, c3;
  logic signed [57:0] prod;
  logic [1:0]         hcnt;
  logic signed [31:0] res_y;
  logic [7:0]         res_seg;

  logic [NW-1:0] nm2;
  logic [NW:0]   msum;
  logic [AW-1:0] mid;
  assign nm2  = n_q - NW'(2);
  assign msum = {1'b0, hi} + {1'b0, lo1} - (NW+1)'(1);
  assign mid  = AW'(msum >> 1);

  // segment from the search bound, clamped to 0..n-2
  logic [AW-1:0] seg_srch;
  always_comb begin
    if (lo1 == '0) seg_srch = '0;
    else if ((lo1 - NW'(1)) > nm2) seg_srch = AW'(nm2);
    else seg_srch = AW'(lo1 - NW'(1));
  end

  logic cubic_sel;
  assign cubic_sel = (NW'(seg_srch) > NW'(1)) && ((NW'(seg_srch) + NW'(2)) < n_q);

  // read address per state
  always_comb begin
    case (state)
      S_LAST:  raddr = AW'(n_q - NW'(1));
      S_SRCH:  raddr = mid;
      S_FETCH: begin
        case (fc)
          3'd0:    raddr = seg_i;
          3'd1:    raddr = seg_i + AW'(1);
          3'd2:    raddr = seg_i - AW'(1);
          default: raddr = seg_i + AW'(2);
        endcase
      end
      S_FIRST: raddr = AW'(n_q - NW'(1));
      default: raddr = '0;
    endcase
  end

  // divider setup values
  logic signed [32:0] num, den;
  logic               neg;
  assign num = {xq[31], xq} - {xi[31], xi};
  assign den = {x1[31], x1} - {xi[31], xi};
  assign neg = num[32] != den[32];

  // restoring divider step
  logic [33:0] rem_sh;
  logic        rem_ge;
  assign rem_sh = (dcnt == 5'd16) ? rem : {rem[32:0], 1'b0};
  assign rem_ge = rem_sh >= {1'b0, ad};

  // horner coefficients
  logic signed [ACC_W-1:0] eym, ey0, ey1, ey2, a0, a1, a2, coef, t_add;
  logic signed [41:0]      prod_sh;
  assign eym = ACC_W'(ym);
  assign ey0 = ACC_W'(yi);
  assign ey1 = ACC_W'(y1);
  assign ey2 = ACC_W'(y2);
  assign a0  = ey2 - ey1 - eym + ey0;
  assign a1  = eym - ey0 - a0;
  assign a2  = ey1 - eym;
  assign coef = (hcnt == 2'd3) ? c1 : (hcnt == 2'd2) ? c2 : c3;
  assign prod_sh = 42'(prod >>> 16);
  assign t_add = ACC_W'(prod_sh) + coef;

  logic signed [31:0] t_sat;
  always_comb begin
    if (t_add > SAT_MAX) t_sat = 32'sh7fffffff;
    else if (t_add < SAT_MIN) t_sat = 32'sh80000000;
    else t_sat = 32'(t_add);
  end

  assign in_ch.ready = (state == S_IDLE);

  // query sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_ch.valid && in_ch.command == CMD_QUERY) begin
            xq    <= in_ch.x_value;
            n_q   <= n_sat;
            state <= S_FIRST;
          end
        end
        S_FIRST: begin
          x0    <= rd_x;
          y0e   <= rd_y;
          state <= S_LAST;
        end
        S_LAST: begin
          up  <= rd_x >= x0;
          lo1 <= '0;
          hi  <= n_q;
          fc  <= '0;
          if ((x0 < rd_x) ? (xq > rd_x) : (xq < rd_x)) begin
            res_y   <= rd_y;
            res_seg <= 8'(nm2);
            state   <= S_DONE;
          end else if ((x0 < rd_x) ? (xq < x0) : (xq > x0)) begin
            res_y   <= y0e;
            res_seg <= 8'd0;
            state   <= S_DONE;
          end else if (xq == x0) begin
            seg_i <= '0;
            cubic <= 1'b0;
            state <= S_FETCH;
          end else if (xq == rd_x) begin
            seg_i <= AW'(nm2);
            cubic <= 1'b0;
            state <= S_FETCH;
          end else begin
            state <= S_SRCH;
          end
        end
        S_SRCH: begin
          if (hi > lo1) begin
            mid_q <= mid;
            state <= S_CMP;
          end else begin
            seg_i <= seg_srch;
            cubic <= cubic_sel;
            state <= S_FETCH;
          end
        end
        S_CMP: begin
          if ((xq >= rd_x) == up) lo1 <= NW'(mid_q) + NW'(1);
          else hi <= NW'(mid_q);
          state <= S_SRCH;
        end
        S_FETCH: begin
          case (fc)
            3'd1:    begin xi <= rd_x; yi <= rd_y; end
            3'd2:    begin x1 <= rd_x; y1 <= rd_y; end
            3'd3:    ym <= rd_y;
            3'd4:    y2 <= rd_y;
            default: ;
          endcase
          fc <= fc + 3'd1;
          if ((fc == 3'd2 && !cubic) || fc == 3'd4) state <= S_DIVI;
        end
        S_DIVI: begin
          ad   <= den[32] ? 33'(-den) : 33'(den);
          rem  <= {1'b0, (num[32] ? 33'(-num) : 33'(num))};
          dcnt <= 5'd16;
          quo  <= '0;
          if (den == '0) begin
            res_y   <= yi;
            res_seg <= 8'(seg_i);
            state   <= S_DONE;
          end else if (neg) begin
            frac  <= '0;
            state <= S_COEF;
          end else if ({1'b0, (num[32] ? 33'(-num) : 33'(num))} >=
                       {(den[32] ? 33'(-den) : 33'(den)), 1'b0}) begin
            frac  <= FRAC_ONE;
            state <= S_COEF;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          rem  <= rem_ge ? rem_sh - {1'b0, ad} : rem_sh;
          quo  <= {quo[15:0], rem_ge};
          dcnt <= dcnt - 5'd1;
          if (dcnt == 5'd0) begin
            frac  <= ({quo[15:0], rem_ge} > FRAC_ONE) ? FRAC_ONE : {quo[15:0], rem_ge};
            state <= S_COEF;
          end
        end
        S_COEF: begin
          res_seg <= 8'(seg_i);
          c3      <= ey0;
          if (cubic) begin
            t    <= a0;
            c1   <= a1;
            c2   <= a2;
            hcnt <= 2'd3;
          end else begin
            t    <= ey1 - ey0;
            hcnt <= 2'd1;
          end
          state <= S_MUL;
        end
        S_MUL: begin
          prod  <= t * $signed({1'b0, frac});
          state <= S_ADD;
        end
        S_ADD: begin
          t    <= t_add;
          hcnt <= hcnt - 2'd1;
          if (hcnt == 2'd1) begin
            res_y <= t_sat;
            state <= S_DONE;
          end else begin
            state <= S_MUL;
          end
        end
        S_DONE: begin
          if (!out_ch.valid || out_ch.ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (state == S_DONE && (!out_ch.valid || out_ch.ready)) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!out_ch.valid || out_ch.ready)) begin
      out_ch.y_result      <= res_y;
      out_ch.segment_found <= res_seg;
    end
  end

  // a new result only comes from the final state
  a_rose_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_ch.valid) |-> $past(state == S_DONE))
    else $error("result without finished query");

  // search window stays inside the table
  a_search_bounds: assert property (@(posedge clk) disable iff (rst)
    state == S_CMP |-> (hi > lo1) && (hi <= n_q))
    else $error("search window out of range");

  // fraction never exceeds one and the horner step count is not zero
  a_frac_range: assert property (@(posedge clk) disable iff (rst)
    state == S_MUL |-> frac <= FRAC_ONE && hcnt != 2'd0)
    else $error("fraction or step count out of range");

  // divider step counter never exceeds sixteen; the divider runs seventeen steps
  a_div_count: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> dcnt <= 5'd16)
    else $error("divider step count out of range");

endmodule
`default_nettype wire
